// ----- rtl/csa_pkg.sv -----
package csa_pkg;

    // request kinds
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    // result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOFIT   = 2'd1;
    localparam logic [1:0] ST_IGNORED = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_PORT_BASE = 2'd0;
    localparam logic [1:0] CFG_RSV_A     = 2'd1;
    localparam logic [1:0] CFG_RSV_B     = 2'd2;

    // configuration reset values
    localparam logic [15:0] PORT_BASE_RST = 16'd0;
    localparam logic [7:0]  RSV_A_RST     = 8'd1;
    localparam logic [7:0]  RSV_B_RST     = 8'd0;

    typedef struct packed {
        logic        req_type;
        logic [8:0]  count;
        logic [15:0] port;
    } t_req;

    typedef struct packed {
        logic [15:0] port_out;
        logic [1:0]  status;
    } t_rsp;

endpackage

// ----- rtl/contiguous_slot_allocator_unit.sv -----
// channel   | direction | handshake               | beat
// ----------+-----------+-------------------------+---------------------------------
// request   | in        | i_valid / o_stall       | t_req: req_type, count, port
// response  | out       | o_valid / i_stall       | t_rsp: port_out, status
// config    | in        | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// one request at a time; the slot bitmap is a one-port-write, one-port-read memory
// allocate: scans the bitmap from slot zero, one slot per cycle, then marks the run found
// free: clears count slots; a free of port zero or an oversized allocate skips to done
// after reset a clearing pass over every slot wipes the bitmap; requests stall meanwhile
// reset is synchronous, active low; the response register lets a new request in while
// an earlier response still waits on i_stall
module contiguous_slot_allocator_unit
    import csa_pkg::*;
#(
    parameter int SLOTS = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_valid,
    output logic        o_stall,
    input  t_req        i_req,
    // response channel
    output logic        o_valid,
    input  logic        i_stall,
    output t_rsp        o_rsp,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam int IW   = $clog2(SLOTS);          // slot index width
    localparam int CW   = IW + 1;                 // width that holds SLOTS itself
    localparam int CMPW = (CW > 9) ? CW : 9;      // run length compare width
    localparam int RW   = (IW > 8) ? IW : 8;      // reserved slot compare width
    localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);

    typedef enum logic [2:0] {
        S_CLR,
        S_IDLE,
        S_SCAN,
        S_MARK,
        S_FREE,
        S_DONE
    } t_state;

    // bitmap memory, no reset: the clearing pass wipes it
    logic mem [SLOTS];

    t_state            r_state,      n_state;
    logic [IW-1:0]     r_idx,        n_idx;
    logic [CMPW-1:0]   r_run,        n_run;
    logic [8:0]        r_num,        n_num;
    logic [8:0]        r_rem,        n_rem;
    logic signed [17:0] r_fidx,      n_fidx;
    logic [15:0]       r_res_port,   n_res_port;
    logic [1:0]        r_res_status, n_res_status;
    logic              r_out_vld,    n_out_vld;
    t_rsp              r_out_rsp,    n_out_rsp;
    logic [15:0]       r_port_base,  n_port_base;
    logic [7:0]        r_rsv_a,      n_rsv_a;
    logic [7:0]        r_rsv_b,      n_rsv_b;
    logic              r_rd;

    logic          req_acc;
    logic          out_free;
    logic [8:0]    req_num;
    logic          slot_busy;
    logic [CMPW-1:0] run_inc;
    logic [IW-1:0] run_start;
    logic          free_in_range;
    logic          mem_we;
    logic [IW-1:0] mem_wa;
    logic          mem_wd;
    logic [IW-1:0] rd_addr;

    assign o_stall     = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_out_vld;
    assign o_rsp       = r_out_rsp;

    assign req_acc  = i_valid && !o_stall;
    assign out_free = !r_out_vld || !i_stall;
    assign req_num  = (i_req.count == 9'd0) ? 9'd1 : i_req.count;

    // r_rd holds the bitmap bit of r_idx while scanning; reserved slots always look used
    assign slot_busy = r_rd
                    || (RW'(r_idx) == RW'(r_rsv_a))
                    || (RW'(r_idx) == RW'(r_rsv_b));
    assign run_inc   = r_run + CMPW'(1);
    assign run_start = IW'(CMPW'(r_idx) + CMPW'(1) - CMPW'(r_num));

    // free target in range: not negative and below SLOTS
    assign free_in_range = !r_fidx[17] && (r_fidx[16:0] < 17'(SLOTS));

    // memory ports
    always_comb begin
        mem_we  = 1'b0;
        mem_wa  = r_idx;
        mem_wd  = 1'b0;
        rd_addr = r_idx;
        unique case (r_state)
            S_CLR: begin
                mem_we = 1'b1;
            end
            S_IDLE: begin
                rd_addr = '0;                 // prefetch slot zero for a scan
            end
            S_SCAN: begin
                rd_addr = r_idx + IW'(1);     // prefetch the following slot
            end
            S_MARK: begin
                mem_we = 1'b1;
                mem_wd = 1'b1;
            end
            S_FREE: begin
                mem_we = free_in_range;
                mem_wa = r_fidx[IW-1:0];
            end
            S_DONE: begin
                mem_we = 1'b0;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rd <= mem[rd_addr];
    end

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_run        = r_run;
        n_num        = r_num;
        n_rem        = r_rem;
        n_fidx       = r_fidx;
        n_res_port   = r_res_port;
        n_res_status = r_res_status;
        n_out_vld    = r_out_vld;
        n_out_rsp    = r_out_rsp;
        n_port_base  = r_port_base;
        n_rsv_a      = r_rsv_a;
        n_rsv_b      = r_rsv_b;

        // response taken downstream
        if (r_out_vld && !i_stall) begin
            n_out_vld = 1'b0;
        end

        // configuration writes are taken in any state
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_PORT_BASE: n_port_base = i_cfg_data;
                CFG_RSV_A:     n_rsv_a     = i_cfg_data[7:0];
                CFG_RSV_B:     n_rsv_b     = i_cfg_data[7:0];
                default:       n_port_base = r_port_base;
            endcase
        end

        unique case (r_state)
            S_CLR: begin
                n_idx = r_idx + IW'(1);
                if (r_idx == LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (req_acc) begin
                    n_num        = req_num;
                    n_rem        = req_num;
                    n_idx        = '0;
                    n_run        = '0;
                    n_res_port   = 16'd0;
                    n_res_status = ST_OK;
                    n_fidx       = $signed({2'b00, i_req.port})
                                 - $signed({2'b00, r_port_base});
                    if (i_req.req_type == REQ_ALLOC) begin
                        if (CMPW'(req_num) > CMPW'(SLOTS)) begin
                            n_res_status = ST_NOFIT;
                            n_state      = S_DONE;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end else if (i_req.port == 16'd0) begin
                        n_res_status = ST_IGNORED;
                        n_state      = S_DONE;
                    end else begin
                        n_state = S_FREE;
                    end
                end
            end
            S_SCAN: begin
                n_run = slot_busy ? '0 : run_inc;
                if (!slot_busy && run_inc == CMPW'(r_num)) begin
                    // first fit found, go back and mark the run
                    n_idx      = run_start;
                    n_res_port = 16'(run_start) + r_port_base;
                    n_state    = S_MARK;
                end else if (r_idx == LAST) begin
                    n_res_status = ST_NOFIT;
                    n_state      = S_DONE;
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end
            S_MARK: begin
                n_idx = r_idx + IW'(1);
                n_rem = r_rem - 9'd1;
                if (r_rem == 9'd1) begin
                    n_state = S_DONE;
                end
            end
            S_FREE: begin
                n_fidx = r_fidx + 18'sd1;
                n_rem  = r_rem - 9'd1;
                if (r_rem == 9'd1) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_vld          = 1'b1;
                    n_out_rsp.port_out = r_res_port;
                    n_out_rsp.status   = r_res_status;
                    n_state            = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_idx       <= '0;
            r_out_vld   <= 1'b0;
            r_port_base <= PORT_BASE_RST;
            r_rsv_a     <= RSV_A_RST;
            r_rsv_b     <= RSV_B_RST;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_out_vld   <= n_out_vld;
            r_port_base <= n_port_base;
            r_rsv_a     <= n_rsv_a;
            r_rsv_b     <= n_rsv_b;
        end
        r_run        <= n_run;
        r_num        <= n_num;
        r_rem        <= n_rem;
        r_fidx       <= n_fidx;
        r_res_port   <= n_res_port;
        r_res_status <= n_res_status;
        r_out_rsp    <= n_out_rsp;
    end

endmodule

// ----- rtl/csa_checker.sv -----
module csa_checker
    import csa_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_stall,
    input logic o_valid,
    input logic i_stall,
    input t_rsp o_rsp
);

    // a stalled response beat holds
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_rsp))
        else $error("response changed while stalled");

    // status is one of the defined codes
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_rsp.status == ST_OK || o_rsp.status == ST_NOFIT
                     || o_rsp.status == ST_IGNORED))
        else $error("undefined status code");

    // a failed or ignored request carries port zero
    a_fail_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_rsp.status != ST_OK |-> o_rsp.port_out == 16'd0)
        else $error("nonzero port on failed request");

    // an accepted request makes the block busy
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("request taken without going busy");

    // reset drops the response
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("response valid after reset");

endmodule

bind contiguous_slot_allocator_unit csa_checker u_csa_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_rsp   (o_rsp)
);

// ----- tb/sv/contiguous_slot_allocator_checker.sv -----
module contiguous_slot_allocator_checker
    import csa_pkg::*;
#(
    parameter int SLOTS = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    input  logic        i_req_stall,
    input  t_req        i_req,
    input  logic        i_rsp_valid,
    input  logic        i_rsp_stall,
    input  t_rsp        i_rsp,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);

    logic [SLOTS-1:0] slot_used;
    logic [15:0]      port_base;
    logic [7:0]       rsv_a;
    logic [7:0]       rsv_b;
    t_rsp             awaited_rsps[$];
    int               mismatches = 0;

    function automatic bit slot_taken(input int s);
        return slot_used[s] || s == int'(rsv_a) || s == int'(rsv_b);
    endfunction

    // updates the slot map for one request, returns its response
    function automatic t_rsp apply_request(input t_req req);
        t_rsp rsp;
        int   num;
        int   run_len;
        int   start;
        int   first;
        int   idx;
        bit   found;
        rsp.port_out = 16'd0;
        rsp.status   = ST_OK;
        num = (req.count == 9'd0) ? 1 : int'(req.count);
        if (req.req_type == REQ_ALLOC) begin
            run_len = 0;
            start   = 0;
            found   = 1'b0;
            if (num <= SLOTS) begin
                for (int i = 0; i < SLOTS && !found; i++) begin
                    if (slot_taken(i)) begin
                        run_len = 0;
                    end else begin
                        run_len++;
                        if (run_len == num) begin
                            start = i + 1 - num;
                            found = 1'b1;
                        end
                    end
                end
            end
            if (found) begin
                for (int i = start; i < start + num; i++) slot_used[i] = 1'b1;
                rsp.port_out = 16'(start) + port_base;
            end else begin
                rsp.status = ST_NOFIT;
            end
        end else if (req.port == 16'd0) begin
            rsp.status = ST_IGNORED;
        end else begin
            first = int'(req.port) - int'(port_base);
            for (int k = 0; k < num; k++) begin
                idx = first + k;
                if (idx >= 0 && idx < SLOTS) slot_used[idx] = 1'b0;
            end
        end
        return rsp;
    endfunction

    always @(posedge i_clk) begin
        t_rsp want;
        if (!i_rst_n) begin
            slot_used = '0;
            port_base = PORT_BASE_RST;
            rsv_a     = RSV_A_RST;
            rsv_b     = RSV_B_RST;
            awaited_rsps.delete();
        end else begin
            // retire the response first: it never belongs to a request taken at this edge
            if (i_rsp_valid && !i_rsp_stall) begin
                if (awaited_rsps.size() == 0) begin
                    $error("unexpected response beat: port_out %0d status %0d",
                           i_rsp.port_out, i_rsp.status);
                    mismatches++;
                end else begin
                    want = awaited_rsps.pop_front();
                    if (i_rsp.port_out !== want.port_out) begin
                        $error("port_out: expected %0d, actual %0d",
                               want.port_out, i_rsp.port_out);
                        mismatches++;
                    end
                    if (i_rsp.status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, i_rsp.status);
                        mismatches++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_PORT_BASE: port_base = i_cfg_data;
                    CFG_RSV_A:     rsv_a = i_cfg_data[7:0];
                    CFG_RSV_B:     rsv_b = i_cfg_data[7:0];
                    default:       ;
                endcase
            end
            if (i_req_valid && !i_req_stall) awaited_rsps.push_back(apply_request(i_req));
        end
        o_pending    <= awaited_rsps.size();
        o_fail_count <= mismatches;
    end

endmodule

// ----- tb/sv/contiguous_slot_allocator_unit_test.sv -----
module contiguous_slot_allocator_unit_test;
    import csa_pkg::*;

    localparam int SLOTS            = 256;
    localparam int PHASES           = 6;
    localparam int ITEMS_PER_PHASE  = 288;
    // long receiver hold-off so the response register and the request side back up
    localparam int HOLD_CYCLES      = 400;
    // worst single request: full scan plus a full-width mark, with margin
    localparam int DRAIN_CYCLES     = 600;
    // covers the clearing pass, the hold-off and the slowest request several times over
    localparam int WATCHDOG_LIMIT   = 6000;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_valid     = 1'b0;
    logic        o_stall;
    t_req        i_req       = '0;
    logic        o_valid;
    logic        i_stall     = 1'b0;
    t_rsp        o_rsp;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = CFG_PORT_BASE;
    logic [15:0] i_cfg_data  = '0;

    int          fail_count;
    int          pending;
    int          idle_cycles = 0;
    bit          send_calm   = 1'b0;
    // stimulus-side copy of the base, used to aim frees at live slots
    logic [15:0] cur_base    = PORT_BASE_RST;

    contiguous_slot_allocator_unit #(
        .SLOTS(SLOTS)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_req      (i_req),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_rsp      (o_rsp),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    contiguous_slot_allocator_checker #(
        .SLOTS(SLOTS)
    ) map_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_valid),
        .i_req_stall (o_stall),
        .i_req       (i_req),
        .i_rsp_valid (o_valid),
        .i_rsp_stall (i_stall),
        .i_rsp       (o_rsp),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // per-beat random wait, with calm stretches where nobody idles
    function automatic int draw_wait(inout bit calm);
        if ($urandom_range(0, 39) == 0) calm = !calm;
        return calm ? 0 : $urandom_range(0, 9);
    endfunction

    function automatic t_req make_req(input logic kind, input int count, input int port);
        t_req r;
        r.req_type = kind;
        r.count    = count[8:0];
        r.port     = port[15:0];
        return r;
    endfunction

    // mostly well-formed traffic: small allocations and frees aimed at the slot range,
    // with oversized runs, stray ports and port-zero frees mixed in
    function automatic t_req random_req(input logic [15:0] base);
        int pick;
        int len;
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            len = $urandom_range(0, 99);
            if (len < 10)      len = 0;
            else if (len < 85) len = $urandom_range(1, 12);
            else if (len < 95) len = $urandom_range(13, 64);
            else if (len < 99) len = $urandom_range(65, 256);
            else               len = $urandom_range(257, 511);
            return make_req(REQ_ALLOC, len, $urandom);
        end
        if (pick < 88) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 300) : $urandom_range(0, 24);
            return make_req(REQ_FREE, len, int'(base) + $urandom_range(0, SLOTS - 1));
        end
        if (pick < 95) return make_req(REQ_FREE, $urandom_range(0, 511), $urandom_range(0, 65535));
        return make_req(REQ_FREE, $urandom_range(0, 511), 0);
    endfunction

    // offer one request beat and hold it until the block takes it
    task automatic send_req(input t_req req);
        int gap;
        gap = draw_wait(send_calm);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_req   <= req;
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    // every request gets a response, so an empty expectation list means the block is idle
    task automatic wait_idle();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic put_reg(input logic [1:0] idx, input logic [15:0] data);
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    // upper data bits of the slot registers are junk on purpose, the block must drop them
    task automatic set_config(input logic [15:0] base, input logic [7:0] a, input logic [7:0] b);
        put_reg(CFG_PORT_BASE, base);
        put_reg(CFG_RSV_A, {8'($urandom), a});
        put_reg(CFG_RSV_B, {8'($urandom), b});
        i_cfg_valid <= 1'b0;
        cur_base = base;
    endtask

    // response side: random stall per beat, plus two long hold-offs to back up the block
    initial begin
        int  w;
        int  beats;
        bit  calm;
        beats = 0;
        calm  = 1'b0;
        forever begin
            w = (beats == 150 || beats == 1200) ? HOLD_CYCLES : draw_wait(calm);
            if (w > 0) begin
                i_stall <= 1'b1;
                repeat (w) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
            beats++;
        end
    end

    // watchdog: too long without any beat on any channel ends the run
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        logic [15:0] base;
        logic [7:0]  ra;
        logic [7:0]  rb;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part, reset configuration: base 0, slots 0 and 1 reserved
        send_req(make_req(REQ_ALLOC, 0, 0));          // zero count means one slot
        send_req(make_req(REQ_ALLOC, 1, 16'hFFFF));   // port is ignored on allocate
        send_req(make_req(REQ_ALLOC, 256, 0));        // full-width run blocked by reserved slots
        send_req(make_req(REQ_ALLOC, 257, 0));        // longer than the map
        send_req(make_req(REQ_ALLOC, 511, 0));
        send_req(make_req(REQ_FREE, 5, 0));           // free of port zero is ignored
        send_req(make_req(REQ_FREE, 0, 3));
        send_req(make_req(REQ_FREE, 1, 1));           // reserved slot stays used after a free
        send_req(make_req(REQ_ALLOC, 3, 0));
        send_req(make_req(REQ_FREE, 300, 2));         // tail beyond the map is skipped
        send_req(make_req(REQ_FREE, 511, 65535));     // wholly outside the map
        send_req(make_req(REQ_ALLOC, 254, 0));        // fills every free slot
        send_req(make_req(REQ_ALLOC, 1, 0));          // nothing left
        send_req(make_req(REQ_FREE, 10, 200));
        send_req(make_req(REQ_FREE, 10, 200));        // clearing already clear slots
        send_req(make_req(REQ_ALLOC, 11, 0));         // one slot too long for the hole
        send_req(make_req(REQ_ALLOC, 10, 0));

        // top base so the returned port wraps, both reserved slots on the last index
        wait_idle();
        set_config(16'hFFFF, 8'd255, 8'd255);
        send_req(make_req(REQ_FREE, 256, 16'hFFFF));  // clears the whole map
        send_req(make_req(REQ_ALLOC, 1, 0));
        send_req(make_req(REQ_ALLOC, 1, 0));          // slot one wraps to port zero
        send_req(make_req(REQ_FREE, 2, 16'hFFFE));    // run starts one below slot zero
        send_req(make_req(REQ_FREE, 256, 16'hFFFF));
        send_req(make_req(REQ_ALLOC, 255, 0));
        send_req(make_req(REQ_FREE, 256, 16'hFFFF));

        // random phases, each under its own register setting
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin base = PORT_BASE_RST; ra = RSV_A_RST; rb = RSV_B_RST; end
                1: begin base = 16'hFFFF; ra = 8'd255; rb = 8'd0; end
                3: begin base = 16'hFF80; ra = 8'd0; rb = 8'd0; end  // map straddles the wrap
                4: begin base = 16'($urandom); ra = 8'd255; rb = 8'd254; end
                default: begin base = 16'($urandom); ra = 8'($urandom); rb = 8'($urandom); end
            endcase
            wait_idle();
            set_config(base, ra, rb);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) send_req(random_req(cur_base));
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/csa_pkg.sv
rtl/contiguous_slot_allocator_unit.sv
rtl/csa_checker.sv
tb/sv/contiguous_slot_allocator_checker.sv
tb/sv/contiguous_slot_allocator_unit_test.sv
